### src/ddo_pkg.sv
// Shared types and constants for the differential drive odometry block.
// Used by the controller, the datapath and the top level.
`default_nettype none
package ddo_pkg;

	localparam int CountW = 32;
	localparam int PoseW  = 48;
	localparam int MoveW  = 32;
	localparam int TurnW  = 40;
	localparam int CordW  = 34;
	localparam int InDataW  = 208;
	localparam int OutDataW = 144;

	localparam logic [29:0] KinvQ30 = 30'd652032874;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DELTA, ST_MUL_T, ST_MUL_L, ST_MUL_H, ST_ANGLE, ST_FOLD,
		ST_ITER, ST_SC_LO, ST_SC_HI, ST_SC_ADD, ST_WRITE
	} ddo_state_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_ACCEPT, OP_DELTA, OP_MUL_T, OP_MUL_L, OP_MUL_H, OP_ANGLE,
		OP_FOLD, OP_ITER, OP_SC_LO, OP_SC_HI, OP_SC_ADD, OP_WRITE
	} ddo_op_t;

	typedef struct packed {
		ddo_op_t op;
		logic    axis;
	} ddo_cmd_t;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// Register indexes on the configuration port.
	localparam logic CFG_MOVE = 1'b0;
	localparam logic CFG_TURN = 1'b1;

	// Arctangent of 2^-i in 2^-32 turn units.
	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0: r = 32'd536870912;
				5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;
				5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;
				5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;
				5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;
				5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;
				5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;
				5'd19: r = 32'd1304;
				5'd20: r = 32'd652;
				5'd21: r = 32'd326;
				5'd22: r = 32'd163;
				5'd23: r = 32'd81;
				5'd24: r = 32'd41;
				5'd25: r = 32'd20;
				5'd26: r = 32'd10;
				5'd27: r = 32'd5;
				5'd28: r = 32'd3;
				5'd29: r = 32'd1;
				5'd30: r = 32'd1;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

### src/ddo_ctrl.sv
// Sequencer for the odometry update: walks the datapath through its steps.
// Depends on ddo_pkg for the state and command types.
`default_nettype none
module ddo_ctrl import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = 24,
	parameter int STEP_W = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_cmd,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output ddo_cmd_t               cmd,
	output logic [STEP_W-1:0]      step
);

	localparam logic [STEP_W-1:0] LastStep = STEP_W'(CORDIC_STEPS - 1);

	ddo_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic axis_q;
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			axis_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FOLD) step_q <= '0;
			else if (state_q == ST_ITER) step_q <= step_q + 1'b1;
			if (state_q == ST_ITER) axis_q <= 1'b0;
			else if (state_q == ST_SC_ADD) axis_q <= 1'b1;
			if (cmd.op == OP_WRITE) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd.op   = OP_NOP;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_ACCEPT;
					state_d = (s_cmd == CMD_LOAD) ? ST_WRITE : ST_DELTA;
				end
			end
			ST_DELTA: begin cmd.op = OP_DELTA; state_d = ST_MUL_T; end
			ST_MUL_T: begin cmd.op = OP_MUL_T; state_d = ST_MUL_L; end
			ST_MUL_L: begin cmd.op = OP_MUL_L; state_d = ST_MUL_H; end
			ST_MUL_H: begin cmd.op = OP_MUL_H; state_d = ST_ANGLE; end
			ST_ANGLE: begin cmd.op = OP_ANGLE; state_d = ST_FOLD; end
			ST_FOLD:  begin cmd.op = OP_FOLD;  state_d = ST_ITER; end
			ST_ITER: begin
				cmd.op = OP_ITER;
				if (step_q == LastStep) state_d = ST_SC_LO;
			end
			ST_SC_LO: begin cmd.op = OP_SC_LO; state_d = ST_SC_HI; end
			ST_SC_HI: begin cmd.op = OP_SC_HI; state_d = ST_SC_ADD; end
			ST_SC_ADD: begin
				cmd.op  = OP_SC_ADD;
				state_d = axis_q ? ST_WRITE : ST_SC_LO;
			end
			ST_WRITE: begin
				// The result register must be free or emptying this cycle.
				if (!valid_q || m_tready) begin
					cmd.op  = OP_WRITE;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign step     = step_q;
	assign m_tvalid = valid_q;

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_WRITE |-> (!valid_q || m_tready))
		else $error("result overwritten while still pending");
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_WRITE |=> valid_q)
		else $error("written result not presented");
	a_load_short: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACCEPT && s_cmd == CMD_LOAD) |=> state_q == ST_WRITE)
		else $error("pose load did not go straight to write");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ITER |-> step_q <= LastStep)
		else $error("rotation counter out of range");

endmodule
`default_nettype wire

### src/ddo_dp.sv
// Datapath of the odometry block: config, pose state, multiplies, CORDIC.
// Depends on ddo_pkg; steered by ddo_ctrl through a command struct.
`default_nettype none
module ddo_dp import ddo_pkg::*; #(
	parameter int STEP_W = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ddo_cmd_t             cmd,
	input  wire logic [STEP_W-1:0]    step,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [TurnW-1:0]     cfg_data,
	input  wire logic                 s_cmd,
	input  wire logic [InDataW-1:0]   s_data,
	output logic [OutDataW-1:0]       m_data
);

	localparam logic signed [CordW-1:0] QuarterTurn = CordW'(34'sd1073741824);
	localparam logic signed [CordW-1:0] HalfTurn    = CordW'(34'sd2147483648);

	logic [MoveW-1:0] move_q;
	logic [TurnW-1:0] turnpc_q;
	logic [PoseW-1:0] px_q, py_q, ph_q;
	logic [CountW-1:0] last_l_q, last_r_q, left_q, right_q;
	logic signed [CountW:0] sum_q, diff_q;
	logic tneg_q;
	logic [PoseW-1:0] tmag_q;
	logic [48:0] turn_q;
	logic [31:0] a32_q;
	logic signed [CordW-1:0] cx_q, cy_q, cz_q;
	logic flip_q;
	logic [30:0] fm_q;
	logic neg_q;
	logic [60:0] prod_q;
	logic [PoseW-1:0] r_q;
	logic [OutDataW-1:0] out_q;

	logic [CountW-1:0] dl, dr;
	logic [CountW:0] smag;
	logic [63:0] tprod;
	logic [63:0] tround;
	logic signed [53:0] plo, phi;
	logic [48:0] mid;
	logic signed [CordW-1:0] z0, xs, ys, at;
	logic signed [CordW-1:0] f;
	logic [30:0] fm;
	logic [48:0] hi_prod;
	logic [61:0] lo_round;
	logic [PoseW-1:0] step_add;

	always_comb begin
		dl     = last_l_q - left_q;
		dr     = right_q - last_r_q;
		smag   = sum_q[CountW] ? (CountW+1)'(-sum_q) : sum_q;
		tprod  = 64'(smag * move_q);
		tround = tprod + 64'd32768;
		plo    = $signed(diff_q) * $signed({1'b0, turnpc_q[19:0]});
		phi    = $signed(diff_q) * $signed({1'b0, turnpc_q[39:20]});
		mid    = {1'b0, ph_q + turn_q[48:1]} + 49'd32768;
		z0     = {{2{a32_q[31]}}, a32_q};
		xs     = cx_q >>> step;
		ys     = cy_q >>> step;
		at     = $signed({2'b00, atan_at(5'(step))});
		f      = cmd.axis ? (flip_q ? -cy_q : cy_q) : (flip_q ? -cx_q : cx_q);
		fm     = f[CordW-1] ? 31'(-f) : 31'(f);
		hi_prod  = 49'(tmag_q[47:30] * fm_q);
		lo_round = 62'(prod_q) + 62'd536870912;
		step_add = neg_q ? PoseW'(-r_q) : r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_q   <= '0;
			turnpc_q <= '0;
			px_q     <= '0;
			py_q     <= '0;
			ph_q     <= '0;
			last_l_q <= '0;
			last_r_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MOVE: move_q   <= cfg_data[MoveW-1:0];
					CFG_TURN: turnpc_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_ACCEPT && s_cmd == CMD_LOAD) begin
				px_q <= s_data[111:64];
				py_q <= s_data[159:112];
				ph_q <= s_data[207:160];
			end
			if (cmd.op == OP_DELTA) begin
				last_l_q <= left_q;
				last_r_q <= right_q;
			end
			if (cmd.op == OP_ANGLE) ph_q <= ph_q + turn_q[47:0];
			if (cmd.op == OP_SC_ADD) begin
				if (cmd.axis) py_q <= py_q + step_add;
				else px_q <= px_q + step_add;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				left_q  <= s_data[31:0];
				right_q <= s_data[63:32];
			end
			OP_DELTA: begin
				sum_q  <= $signed({dr[31], dr}) + $signed({dl[31], dl});
				diff_q <= $signed({dr[31], dr}) - $signed({dl[31], dl});
			end
			OP_MUL_T: begin
				tneg_q <= sum_q[CountW];
				tmag_q <= tround[63:16];
			end
			OP_MUL_L: turn_q <= plo[48:0];
			OP_MUL_H: turn_q <= turn_q + {phi[28:0], 20'd0};
			OP_ANGLE: a32_q <= mid[47:16];
			OP_FOLD: begin
				cx_q <= $signed({4'd0, KinvQ30});
				cy_q <= '0;
				if (z0 > QuarterTurn) begin
					cz_q <= z0 - HalfTurn;
					flip_q <= 1'b1;
				end else if (z0 < -QuarterTurn) begin
					cz_q <= z0 + HalfTurn;
					flip_q <= 1'b1;
				end else begin
					cz_q <= z0;
					flip_q <= 1'b0;
				end
			end
			OP_ITER: begin
				if (!cz_q[CordW-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
			end
			OP_SC_LO: begin
				fm_q   <= fm;
				neg_q  <= tneg_q ^ f[CordW-1];
				prod_q <= 61'(tmag_q[29:0] * fm);
			end
			OP_SC_HI: r_q <= PoseW'(hi_prod) + PoseW'(lo_round[61:30]);
			OP_WRITE: out_q <= {ph_q, py_q, px_q};
			default: ;
		endcase
	end

	assign m_data = out_q;

endmodule
`default_nettype wire

### src/differential_drive_odometry.sv
// Top level of the differential drive wheel odometry block.
// Joins ddo_ctrl and ddo_dp; types come from ddo_pkg.
//
// Use: each input word on the s_ channel is either an encoder update
// (s_tuser = 0: left and right counts) or a pose load (s_tuser = 1:
// set_x, set_y, set_heading). Every word gives exactly one output word on
// the m_ channel holding the pose after it. Two registers, move_per_count
// (index 0) and turn_per_count (index 1), are written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block is
// idle, as the block itself does not enforce it. A pose load goes from
// acceptance straight to the write step; an update runs through the
// delta, split multiply, angle and fold steps, the one-rotation-per-cycle
// CORDIC loop over CORDIC_STEPS rotations and the scaling steps of each
// axis before the write step. One word is in work at a time.
// The result sits in an output register, so a new word is accepted while
// the previous result still waits; if the receiver stalls, the finished
// pose waits in the write step until the output register frees.
// Reset clears pose, last counts, registers and all handshake state.
`default_nettype none
module differential_drive_odometry import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// left_count[31:0], right_count[63:32], set_x[111:64],
	// set_y[159:112], set_heading[207:160]
	input  wire logic [InDataW-1:0]   s_tdata,
	// command[0]
	input  wire logic [0:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// pose_x[47:0], pose_y[95:48], pose_heading[143:96]
	output logic [OutDataW-1:0]       m_tdata,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [TurnW-1:0]     cfg_data
);

	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	ddo_cmd_t cmd;
	logic [STEP_W-1:0] step;

	ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS), .STEP_W(STEP_W)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_cmd(s_tuser[0]), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.cmd(cmd), .step(step)
	);

	ddo_dp #(.STEP_W(STEP_W)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .step(step),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_cmd(s_tuser[0]), .s_data(s_tdata),
		.m_data(m_tdata)
	);

endmodule
`default_nettype wire
